/* hw/rtl/sfp_pkg.sv */
// Package with the shared constants, codes and types of the sample frame packer.
package sfp_pkg;

  localparam int MaxChannelsDefault = 16;

  localparam int CountWidth    = 5;
  localparam int DecimWidth    = 8;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 8;
  localparam int SampleWidth   = 16;
  localparam int ChannelWidth  = 4;
  localparam int ByteWidth     = 8;

  localparam logic [ByteWidth-1:0] SyncFirst  = 8'hAA;
  localparam logic [ByteWidth-1:0] SyncSecond = 8'h55;
  localparam logic [ByteWidth-1:0] CheckSeed  = 8'hFF;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] RegChannelCount = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegDecimation   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegRunning      = 2'd2;

  // Item kinds carried on in_tuser
  localparam logic OpPush   = 1'b0;
  localparam logic OpCommit = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYNC1,
    ST_SYNC2,
    ST_SEQ,
    ST_MASK,
    ST_SCAN,
    ST_LO,
    ST_HI,
    ST_CHECK
  } sfp_state_t;

endpackage

/* hw/rtl/sample_frame_packer_core.sv */
// Top level of the sample frame packer: sample store, channel mask and frame sequencer.
//
//  channel | direction | signals                            | contents
//  --------+-----------+------------------------------------+---------------------------------
//  in_     | in        | tvalid tready tdata[23:0] tuser    | push or commit item
//  out_    | out       | tvalid tready tdata[7:0] tlast     | frame bytes, tlast on checksum
//  cfg_    | in        | valid ready index[1:0] data[7:0]   | register writes
//
//  A push, or a commit that only counts or clears the mask, completes in the idle state.
//  A framing commit starts the sequencer, which sends the sync, sequence and mask bytes,
//  scans one channel per cycle, sends both bytes of each marked channel, then the checksum.
//  The input is not ready while a frame is being produced; a stalled output holds the
//  sequencer on the byte it is about to load. Reset is synchronous and clears the control
//  registers but not the checksum, scan indexes, output byte and last flag or sample store.
module sample_frame_packer_core
  import sfp_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannelsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] channel, [19:4] sample, [23:20] zero
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  localparam int MaskBytes = (MAX_CHANNELS + 7) / 8;
  localparam int MbWidth   = (MaskBytes > 1) ? $clog2(MaskBytes) : 1;
  localparam int SelWidth  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IdxWidth  = $clog2(MAX_CHANNELS + 1);

  // Registers
  sfp_state_t                state_r, state_nxt;
  logic [CountWidth-1:0]     count_r, count_nxt;
  logic [DecimWidth-1:0]     decim_r, decim_nxt;
  logic                      running_r, running_nxt;
  logic [MAX_CHANNELS-1:0]   mask_r, mask_nxt;
  logic [ByteWidth-1:0]      seq_r, seq_nxt;
  logic [DecimWidth-1:0]     dcnt_r, dcnt_nxt;
  logic [ByteWidth-1:0]      chk_r, chk_nxt;
  logic [MbWidth-1:0]        mb_r, mb_nxt;
  logic [IdxWidth-1:0]       idx_r, idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ByteWidth-1:0]      out_data_r, out_data_nxt;
  logic                      out_last_r, out_last_nxt;
  logic [SampleWidth-1:0]    store_r [MAX_CHANNELS];

  logic [ChannelWidth-1:0]   in_channel;
  logic [SampleWidth-1:0]    in_sample;
  logic [CountWidth-1:0]     active;
  logic                      can_load;
  logic                      wr_en;
  logic [DecimWidth-1:0]     dcnt_inc;
  logic [MaskBytes*8-1:0]    mask_wide;
  logic [ByteWidth-1:0]      mask_byte;
  logic [SelWidth-1:0]       sel;
  logic [SampleWidth-1:0]    cur_sample;

  assign in_channel = in_tdata[3:0];
  assign in_sample  = in_tdata[19:4];
  assign active     = (count_r > CountWidth'(MAX_CHANNELS)) ? CountWidth'(MAX_CHANNELS) : count_r;
  assign can_load   = !out_valid_r || out_tready;
  assign dcnt_inc   = dcnt_r + 8'd1;
  assign mask_wide  = (MaskBytes*8)'(mask_r);
  assign mask_byte  = mask_wide[mb_r*8 +: 8];
  assign sel        = idx_r[SelWidth-1:0];
  assign cur_sample = store_r[sel];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    decim_nxt     = decim_r;
    running_nxt   = running_r;
    mask_nxt      = mask_r;
    seq_nxt       = seq_r;
    dcnt_nxt      = dcnt_r;
    chk_nxt       = chk_r;
    mb_nxt        = mb_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        RegChannelCount: count_nxt = cfg_data[CountWidth-1:0];
        RegDecimation:   decim_nxt = cfg_data;
        RegRunning:      running_nxt = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OpPush) begin
            if (CountWidth'(in_channel) < active) begin
              wr_en    = 1'b1;
              mask_nxt = mask_r | (MAX_CHANNELS'(1) << in_channel);
            end
          end else if (!running_r) begin
            mask_nxt = '0;
          end else if (dcnt_inc < decim_r) begin
            dcnt_nxt = dcnt_inc;
          end else begin
            dcnt_nxt  = '0;
            state_nxt = ST_SYNC1;
          end
        end
      end
      ST_SYNC1: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = SyncFirst;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = SyncSecond;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_SEQ;
        end
      end
      ST_SEQ: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = seq_r;
          out_last_nxt  = 1'b0;
          chk_nxt       = CheckSeed ^ seq_r;
          seq_nxt       = seq_r + 8'd1;
          mb_nxt        = '0;
          state_nxt     = ST_MASK;
        end
      end
      ST_MASK: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mask_byte;
          out_last_nxt  = 1'b0;
          chk_nxt       = chk_r ^ mask_byte;
          if (mb_r == MbWidth'(MaskBytes - 1)) begin
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            mb_nxt = mb_r + MbWidth'(1);
          end
        end
      end
      ST_SCAN: begin
        // One channel is examined per cycle; only marked channels produce bytes.
        if ((CountWidth+1)'(idx_r) >= (CountWidth+1)'(active)) begin
          state_nxt = ST_CHECK;
        end else if (mask_r[sel]) begin
          state_nxt = ST_LO;
        end else begin
          idx_nxt = idx_r + IdxWidth'(1);
        end
      end
      ST_LO: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cur_sample[7:0];
          out_last_nxt  = 1'b0;
          chk_nxt       = chk_r ^ cur_sample[7:0];
          state_nxt     = ST_HI;
        end
      end
      ST_HI: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = cur_sample[15:8];
          out_last_nxt  = 1'b0;
          chk_nxt       = chk_r ^ cur_sample[15:8];
          idx_nxt       = idx_r + IdxWidth'(1);
          state_nxt     = ST_SCAN;
        end
      end
      ST_CHECK: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = chk_r;
          out_last_nxt  = 1'b1;
          mask_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      decim_r     <= 8'd1;
      running_r   <= 1'b0;
      mask_r      <= '0;
      seq_r       <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      decim_r     <= decim_nxt;
      running_r   <= running_nxt;
      mask_r      <= mask_nxt;
      seq_r       <= seq_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r      <= chk_nxt;
    mb_r       <= mb_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (wr_en) begin
      store_r[SelWidth'(in_channel)] <= in_sample;
    end
  end

endmodule

/* hw/rtl/sfp_checker.sv */
// Port checker for the sample frame packer, bound to the top level.
module sfp_checker
  import sfp_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [23:0]              in_tdata,
  input logic                     in_tuser,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [7:0]               out_tdata,
  input logic                     out_tlast,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [CfgIndexWidth-1:0] cfg_index,
  input logic [CfgDataWidth-1:0]  cfg_data
);

  logic out_acc;
  logic expect_start_r, expect_start_nxt;
  logic after_start_r, after_start_nxt;

  assign out_acc = out_tvalid && out_tready;

  // Track the position within the frame as seen on the output port.
  always_comb begin
    expect_start_nxt = expect_start_r;
    after_start_nxt  = after_start_r;
    if (out_acc) begin
      expect_start_nxt = out_tlast;
      after_start_nxt  = expect_start_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_start_r <= 1'b1;
      after_start_r  <= 1'b0;
    end else begin
      expect_start_r <= expect_start_nxt;
      after_start_r  <= after_start_nxt;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && expect_start_r |-> out_tdata == SyncFirst && !out_tlast)
    else $error("frame does not open with the first sync byte");

  a_frame_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && after_start_r |-> out_tdata == SyncSecond && !out_tlast)
    else $error("second frame byte is not the second sync byte");

endmodule

bind sample_frame_packer_core sfp_checker u_sfp_checker (.*);

/* bench/sample_frame_packer_core_tb.sv */
// Self-checking bench for the sample frame packer: directed table, random phases, byte checks.
module sample_frame_packer_core_tb;
  import sfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCh      = MaxChannelsDefault;
  localparam int MaskBytes  = (MaxCh + 7) / 8;
  localparam int IdleWait   = 64;
  localparam int RandItems  = 435;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 last;
  } frame_beat_t;

  // A directed row is either a register write or an item; typed rows carry their frame,
  // first byte in the top bits of typed_bytes.
  typedef struct packed {
    logic                     is_write;
    logic [CfgIndexWidth-1:0] reg_idx;
    logic [CfgDataWidth-1:0]  reg_val;
    logic                     op;
    logic [ChannelWidth-1:0]  chan;
    logic [SampleWidth-1:0]   smp;
    logic                     typed;
    logic [3:0]               typed_len;
    logic [79:0]              typed_bytes;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = OpPush;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = RegChannelCount;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  // Local copy of the block's state and registers.
  logic [SampleWidth-1:0] store_model [MaxCh];
  logic [MaxCh-1:0]       mask_model = '0;
  logic [7:0]             seq_model = '0;
  logic [7:0]             decim_count_model = '0;
  logic [CountWidth-1:0]  count_reg = '0;
  logic [DecimWidth-1:0]  decim_reg = 8'd1;
  logic                   running_reg = 1'b0;

  frame_beat_t frame_due[$];
  stim_row_t   dir_table[$];
  int          err_count = 0;
  int          cycle_count = 0;
  bit          no_stall = 1'b0;

  sample_frame_packer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("sample_frame_packer_core test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 200) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  function automatic int active_channels();
    return (count_reg > MaxCh) ? MaxCh : int'(count_reg);
  endfunction

  // Applies one accepted item to the local state and queues the frame bytes it causes.
  function automatic void pack_item(input logic op, input logic [ChannelWidth-1:0] chan,
                                    input logic [SampleWidth-1:0] smp, input bit keep);
    logic [ByteWidth-1:0] fb[$];
    logic [ByteWidth-1:0] chk;
    int active;
    int b;
    int i;
    int k;
    active = active_channels();
    if (op == OpPush) begin
      if (chan < active) begin
        store_model[chan] = smp;
        mask_model[chan] = 1'b1;
      end
      return;
    end
    if (!running_reg) begin
      mask_model = '0;
      return;
    end
    decim_count_model = decim_count_model + 8'd1;
    if (decim_count_model < decim_reg) return;
    decim_count_model = '0;
    fb.push_back(SyncFirst);
    fb.push_back(SyncSecond);
    fb.push_back(seq_model);
    seq_model = seq_model + 8'd1;
    for (b = 0; b < MaskBytes; b++) fb.push_back(8'(mask_model >> (8 * b)));
    for (i = 0; i < active; i++) begin
      if (mask_model[i]) begin
        fb.push_back(store_model[i][7:0]);
        fb.push_back(store_model[i][15:8]);
      end
    end
    // The checksum starts at the sequence byte; the two sync bytes are left out.
    chk = CheckSeed;
    for (k = 2; k < fb.size(); k++) chk ^= fb[k];
    mask_model = '0;
    if (keep) begin
      foreach (fb[k]) frame_due.push_back('{fb[k], 1'b0});
      frame_due.push_back('{chk, 1'b1});
    end
  endfunction

  // Frame bytes are checked at the rising edge at which they are taken.
  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_due.size() == 0) begin
        report_mismatch($sformatf("frame byte %02h with nothing expected", out_tdata));
      end else begin
        want = frame_due.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("frame byte %02h, expected %02h", out_tdata, want.data));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last flag %b, expected %b", out_tlast, want.last));
      end
    end
  end

  // Receiver: a fresh stall before every byte, none in quiet phases.
  initial begin
    int stall;
    forever begin
      stall = no_stall ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic send_item(input logic op, input logic [ChannelWidth-1:0] chan,
                           input logic [SampleWidth-1:0] smp, input bit keep);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, smp, chan};
    do @(posedge clk); while (in_tready !== 1'b1);
    pack_item(op, chan, smp, keep);
  endtask

  // Holds the sender until every frame byte is in, then lets the block settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (frame_due.size() != 0) @(negedge clk);
    repeat (IdleWait) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      RegChannelCount: count_reg = val[CountWidth-1:0];
      RegDecimation:   decim_reg = val[DecimWidth-1:0];
      RegRunning:      running_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_write(input logic [CfgIndexWidth-1:0] idx,
                                    input logic [CfgDataWidth-1:0] val);
    dir_table.push_back('{1'b1, idx, val, OpPush, 4'd0, 16'd0, 1'b0, 4'd0, 80'd0});
  endfunction

  function automatic void add_item(input logic op, input logic [ChannelWidth-1:0] chan,
                                   input logic [SampleWidth-1:0] smp, input logic typed,
                                   input logic [3:0] len, input logic [79:0] bytes);
    dir_table.push_back('{1'b0, RegChannelCount, 8'd0, op, chan, smp, typed, len, bytes});
  endfunction

  initial begin
    stim_row_t r;
    int k;
    int effective;
    int phase;
    int items_left;
    int pushes;
    int active;
    logic [CfgDataWidth-1:0] val;
    logic [ChannelWidth-1:0] chan;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Stopped commit straight after reset, with its unused fields at their extremes.
    add_item(OpCommit, 4'hF, 16'hFFFF, 1'b1, 4'd0, 80'd0);
    // No channel is registered yet, so the push is dropped.
    add_item(OpPush, 4'h0, 16'h1111, 1'b1, 4'd0, 80'd0);
    add_write(RegRunning, 8'd1);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b1, 4'd6, 80'hAA_55_00_00_00_FF_00_00_00_00);
    // A count above the channel limit saturates; both end channels and sample extremes.
    add_write(RegChannelCount, 8'd31);
    add_item(OpPush, 4'h0, 16'h7FFF, 1'b0, 4'd0, 80'd0);
    add_item(OpPush, 4'hF, 16'h8000, 1'b0, 4'd0, 80'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b1, 4'd10, 80'hAA_55_01_01_80_FF_7F_00_80_7F);
    // Pushes at or above the count are dropped; a later push overwrites.
    add_write(RegChannelCount, 8'd4);
    add_item(OpPush, 4'h3, 16'h1234, 1'b0, 4'd0, 80'd0);
    add_item(OpPush, 4'h4, 16'hBEEF, 1'b0, 4'd0, 80'd0);
    add_item(OpPush, 4'h3, 16'hFFFF, 1'b0, 4'd0, 80'd0);
    add_item(OpCommit, 4'h5, 16'h5555, 1'b0, 4'd0, 80'd0);
    // Count lowered after the pushes: the mask keeps channel 10 but its sample is not sent.
    add_write(RegChannelCount, 8'd16);
    add_item(OpPush, 4'hA, 16'h0001, 1'b0, 4'd0, 80'd0);
    add_item(OpPush, 4'h2, 16'h8001, 1'b0, 4'd0, 80'd0);
    add_write(RegChannelCount, 8'd5);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    // A commit while stopped clears the mask, so the next frame carries no samples.
    add_item(OpPush, 4'h1, 16'h5A5A, 1'b0, 4'd0, 80'd0);
    add_write(RegRunning, 8'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    add_write(RegRunning, 8'd1);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    // One frame per three commits.
    add_write(RegDecimation, 8'd3);
    add_item(OpPush, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    // A decimation of zero acts as one.
    add_write(RegDecimation, 8'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    // Decimation lowered below the running count: the next commit frames.
    add_write(RegDecimation, 8'd255);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);
    add_write(RegDecimation, 8'd2);
    add_item(OpCommit, 4'h0, 16'h0000, 1'b0, 4'd0, 80'd0);

    foreach (dir_table[i]) begin
      r = dir_table[i];
      if (r.is_write) begin
        write_reg(r.reg_idx, r.reg_val);
      end else if (r.typed) begin
        // The local state still advances; the frame comes from the row itself.
        send_item(r.op, r.chan, r.smp, 1'b0);
        for (k = 0; k < r.typed_len; k++)
          frame_due.push_back('{r.typed_bytes[79 - 8 * k -: 8], k == r.typed_len - 1});
      end else begin
        send_item(r.op, r.chan, r.smp, 1'b1);
      end
    end

    // Random phases: a new setting, then bursts of pushes each closed by a commit.
    effective = 0;
    phase = 0;
    while (effective < RandItems) begin
      case ($urandom_range(0, 7))
        0:       val = 8'd0;
        1:       val = 8'd1;
        2:       val = 8'd16;
        3:       val = 8'd31;
        4:       val = 8'($urandom_range(17, 31));
        default: val = 8'($urandom_range(2, 16));
      endcase
      write_reg(RegChannelCount, val);
      case ($urandom_range(0, 7))
        0:       val = 8'd0;
        1:       val = 8'd255;
        2:       val = 8'd1;
        default: val = 8'($urandom_range(1, 3));
      endcase
      write_reg(RegDecimation, val);
      write_reg(RegRunning, {7'd0, $urandom_range(0, 5) != 0});
      no_stall = ($urandom_range(0, 3) == 0);
      active = active_channels();
      items_left = $urandom_range(30, 60);
      while (items_left > 0 && effective < RandItems) begin
        pushes = $urandom_range(0, active + 2);
        repeat (pushes) begin
          // Mostly registered channels; now and then any channel as noise.
          if (active > 0 && $urandom_range(0, 7) != 0)
            chan = 4'($urandom_range(0, active - 1));
          else
            chan = 4'($urandom_range(0, 15));
          effective++;
          items_left--;
          send_item(OpPush, chan, 16'($urandom), 1'b1);
        end
        send_item(OpCommit, 4'($urandom_range(0, 15)), 16'($urandom), 1'b1);
        effective++;
        items_left--;
      end
      no_stall = 1'b0;
      if (phase % 3 == 1) drain();
      phase++;
    end

    drain();
    if (err_count == 0 && frame_due.size() == 0) begin
      $display("sample_frame_packer_core test passed");
    end else begin
      $display("sample_frame_packer_core test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sfp_pkg.sv
hw/rtl/sample_frame_packer_core.sv
hw/rtl/sfp_checker.sv
bench/sample_frame_packer_core_tb.sv
